### rtl/sida_pkg.sv
// Shared constants, state type and elaboration helpers for the decimal text converter.
package sida_pkg;

	localparam int VALUE_BITS_DEF = 32;

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_MINUS = 8'd45;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} sida_state_t;

	// Number of decimal digits in 2^(bits-1), the largest magnitude to print.
	function automatic int decimal_digits(input int bits);
		longint unsigned p;
		longint unsigned lim;
		int n;
		p   = 64'd1;
		lim = 64'd1 << (bits - 1);
		n   = 0;
		while (p <= lim && n < 20) begin
			p = p * 64'd10;
			n = n + 1;
		end
		return n;
	endfunction

endpackage

### rtl/sida_dabble.sv
// One shift-and-add-3 step of the binary to packed BCD conversion.
module sida_dabble #(
	parameter int DIGITS = 10
) (
	input  logic [DIGITS*4-1:0] bcd,
	input  logic                bit_in,
	output logic [DIGITS*4-1:0] bcd_next
);

	logic [DIGITS*4-1:0] adj;

	// Every digit of five or more gets three added so the shift carries correctly.
	for (genvar d = 0; d < DIGITS; d++) begin : g_digit
		assign adj[d*4 +: 4] = (bcd[d*4 +: 4] >= 4'd5) ? bcd[d*4 +: 4] + 4'd3
			: bcd[d*4 +: 4];
	end

	assign bcd_next = {adj[DIGITS*4-2:0], bit_in};

endmodule

### rtl/signed_int_to_decimal_ascii.sv
// Top level: signed integer in, decimal ASCII characters out, one character per beat.
//
// Each input beat carries one signed two's-complement integer of VALUE_BITS bits
// in the low bits of s_tdata. The block answers with the decimal text of that
// integer as a run of output beats, one ASCII character each, most significant
// digit first: a '-' leads the run for a negative value, leading zeros are
// dropped so that zero prints as a single '0', and m_tlast is high on the final
// digit. The most negative value prints as '-' followed by its full unsigned
// magnitude. Conversion uses a single shift-and-add-3 unit that handles one
// magnitude bit per cycle; leading zeros are then shifted out one digit at a
// time, and the characters follow while the output side keeps taking beats.
// s_tready is high only while the block is idle; the output character sits in
// its own register, so the next integer may be accepted while the final
// character of the previous run still waits for the consumer. Nothing is kept
// between integers.
module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,  // value [VALUE_BITS-1:0], zero padded
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,  // character [7:0]
	output logic                              m_tlast   // last character of the run
);

	import sida_pkg::*;

	localparam int DIGITS = decimal_digits(VALUE_BITS);
	localparam int BCD_W  = DIGITS * 4;
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);
	localparam int REM_W  = $clog2(DIGITS + 1);

	sida_state_t state_q, state_nx;

	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_step;
	logic [CNT_W-1:0]      cnt_q;
	logic [REM_W-1:0]      rem_q;
	logic                  neg_q;

	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  out_last_q;

	logic [VALUE_BITS-1:0] raw;
	logic [3:0]            top_digit;
	logic                  accept;
	logic                  out_free;
	logic                  emit_go;

	assign raw       = s_tdata[VALUE_BITS-1:0];
	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign accept    = s_tvalid && s_tready;
	// The output register may be refilled when it is empty or drained this cycle.
	assign out_free  = !out_valid_q || m_tready;

	sida_dabble #(
		.DIGITS(DIGITS)
	) u_dabble (
		.bcd     (bcd_q),
		.bit_in  (mag_q[VALUE_BITS-1]),
		.bcd_next(bcd_step)
	);

	// Next-state logic of the sequencer.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nx = ST_CONV;
				end
			end
			ST_CONV: begin
				if (cnt_q == CNT_W'(1)) begin
					state_nx = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// Stop skipping at the first non-zero digit, or at the units digit.
				if (top_digit != 4'd0 || rem_q == REM_W'(1)) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free && !neg_q && rem_q == REM_W'(1)) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Handshake and emit decisions of the sequencer.
	always_comb begin
		s_tready = 1'b0;
		emit_go  = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_EMIT: emit_go  = out_free;
			default: begin
				s_tready = 1'b0;
				emit_go  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers; their contents only matter under the sequencer's control.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					neg_q <= raw[VALUE_BITS-1];
					mag_q <= raw[VALUE_BITS-1] ? VALUE_BITS'(~raw + 1'b1) : raw;
					bcd_q <= '0;
					cnt_q <= CNT_W'(VALUE_BITS);
				end
			end
			ST_CONV: begin
				bcd_q <= bcd_step;
				mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
				rem_q <= REM_W'(DIGITS);
			end
			ST_SKIP: begin
				if (top_digit == 4'd0 && rem_q != REM_W'(1)) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
					rem_q <= rem_q - REM_W'(1);
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					if (neg_q) begin
						neg_q <= 1'b0;
					end else begin
						bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
						rem_q <= rem_q - REM_W'(1);
					end
				end
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	// Output character register.
	always_ff @(posedge clk) begin
		if (emit_go) begin
			if (neg_q) begin
				out_char_q <= CH_MINUS;
				out_last_q <= 1'b0;
			end else begin
				out_char_q <= CH_ZERO + {4'd0, top_digit};
				out_last_q <= (rem_q == REM_W'(1));
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

	// An accepted integer always starts conversion in the next cycle.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CONV)
		else $error("accepted beat did not start conversion");

	// Only digits or the minus sign ever leave the block.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == CH_MINUS) ||
			(m_tdata >= CH_ZERO && m_tdata <= CH_ZERO + 8'd9))
		else $error("output character is not a digit or minus sign");

	// A run never ends on the minus sign.
	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tdata != CH_MINUS)
		else $error("run ended on the minus sign");

	// The digit count never runs out while digits are still being skipped or sent.
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_EMIT) |-> rem_q != '0)
		else $error("digit count exhausted during output");

endmodule

### sim/tb_signed_int_to_decimal_ascii.sv
// Self-checking testbench for the signed integer to decimal ASCII converter.
module tb_signed_int_to_decimal_ascii;

	import sida_pkg::*;

	localparam int VALUE_BITS  = 32;
	localparam int DATA_W      = ((VALUE_BITS + 7) / 8) * 8;
	localparam int CLK_HALF    = 4;
	localparam int MAX_GAP     = 12;
	// The drain wait at the end allows a little more than one item's worth of work.
	localparam int DRAIN_CYCLES = 64;
	// The receiver stalls once for this long, well beyond one conversion, so
	// that the block finishes its run, holds its output and refuses new values.
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_AT_BEAT = 200;
	localparam int RANDOM_ITEMS = 300;
	// All 323 items at their slowest, plus the long hold, stay well below this.
	localparam longint CYCLE_LIMIT = 400000;

	// One output beat: an ASCII character and the end-of-text mark.
	typedef struct packed {
		logic [7:0] ch;
		logic       is_last;
	} text_beat_t;

	// Scoreboard: turns each accepted integer into the characters it should
	// produce and compares every output beat against the oldest of them.
	class decimal_text_scoreboard;
		text_beat_t pending_text[$];
		int         mismatches;
		int         n_values;
		int         n_negative;
		int         n_zero;
		int         n_chars;
		int         longest;

		function void note_value(logic [VALUE_BITS-1:0] v);
			logic [VALUE_BITS-1:0] mag;
			logic [7:0]            digits[$];
			logic                  neg;
			int                    len;
			neg = v[VALUE_BITS-1];
			// Negating the most negative value wraps to itself, which read as
			// unsigned is exactly its magnitude.
			mag = neg ? -v : v;
			do begin
				digits.push_front(CH_ZERO + 8'(mag % 10));
				mag = mag / 10;
			end while (mag != 0);
			if (neg)
				pending_text.push_back('{ch: CH_MINUS, is_last: 1'b0});
			foreach (digits[i])
				pending_text.push_back('{ch: digits[i], is_last: (i == digits.size() - 1)});
			len = digits.size() + (neg ? 1 : 0);
			n_values++;
			if (neg)
				n_negative++;
			if (v == '0)
				n_zero++;
			n_chars += len;
			if (len > longest)
				longest = len;
		endfunction

		function void report(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] MISMATCH %s", $time, what);
		endfunction

		function void check_beat(logic [7:0] ch, logic is_last);
			text_beat_t want;
			if (pending_text.size() == 0) begin
				report($sformatf("unexpected beat: char %0d last %0b", ch, is_last));
				return;
			end
			want = pending_text.pop_front();
			if (ch !== want.ch || is_last !== want.is_last)
				report($sformatf("expected char %0d last %0b, got char %0d last %0b",
					want.ch, want.is_last, ch, is_last));
		endfunction

		function int pending();
			return pending_text.size();
		endfunction

		function void check_drained();
			if (pending_text.size() != 0)
				report($sformatf("%0d characters never arrived", pending_text.size()));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // value [VALUE_BITS-1:0], zero padded
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;   // character [7:0]
	logic              m_tlast;   // last character of the run

	decimal_text_scoreboard sb;
	longint cycle_count;
	int     beats_taken;
	int     held_cycles;

	signed_int_to_decimal_ascii #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: a hung handshake must not leave the run spinning forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Gaps are drawn per beat, but every third stretch of 32 beats runs with
	// no idling at all so that back-to-back traffic is covered too.
	function automatic int draw_gap(int idx);
		if ((idx / 32) % 3 == 1)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic longint power_of_ten(int k);
		longint p;
		p = 1;
		repeat (k) p = p * 10;
		return p;
	endfunction

	// Random integers, weighted so that every text length from one to eleven
	// characters turns up often, not just the ten-digit values that a flat
	// draw over 32 bits gives more than half the time.
	function automatic logic [VALUE_BITS-1:0] random_value();
		longint lo;
		longint hi;
		longint m;
		int     d;
		int     sel;
		logic   neg;
		sel = $urandom_range(0, 9);
		neg = 1'($urandom_range(0, 1));
		if (sel <= 3)
			return $urandom;
		if (sel <= 7) begin
			d  = $urandom_range(1, 10);
			lo = (d == 1) ? 0 : power_of_ten(d - 1);
			hi = power_of_ten(d) - 1;
			if (d == 10)
				hi = neg ? 64'd2147483648 : 64'd2147483647;
			m = $urandom_range(32'(hi), 32'(lo));
		end else if (sel == 8) begin
			// Just around a power of ten, where the digit count changes.
			d = $urandom_range(0, 9);
			m = power_of_ten(d) - $urandom_range(0, 1);
		end else begin
			case ($urandom_range(0, 3))
				0: m = 0;
				1: m = 1;
				2: m = 64'd2147483647;
				default: begin
					m   = 64'd2147483648;
					neg = 1'b1;
				end
			endcase
		end
		return VALUE_BITS'(neg ? -m : m);
	endfunction

	// Offer one integer after the given idle gap and hold it until taken.
	// Entered and left at a falling edge.
	task automatic send_value(input logic [VALUE_BITS-1:0] v, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= DATA_W'(v);
		do @(posedge clk); while (!s_tready);
		sb.note_value(v);
		@(negedge clk);
	endtask

	// Output side: stalls a random number of cycles before each beat, and
	// once, part way through the random traffic, holds off for a long stretch
	// so that the block backs up and stops taking input.
	initial begin : receiver
		int stall;
		m_tready    = 1'b0;
		beats_taken = 0;
		held_cycles = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_gap(beats_taken);
			if (beats_taken == HOLD_AT_BEAT) begin
				stall       = HOLD_CYCLES;
				held_cycles = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_beat(m_tdata, m_tlast);
			beats_taken++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int directed[$];
		int n;
		sb          = new;
		cycle_count = 0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed values: zero, single digits, several changes of digit count
		// near powers of ten, both ends of the range including the most
		// negative value, and bit patterns that toggle every data bit.
		directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
			999999999, -999999999, 1000000000, -1000000000, 2147483647,
			-2147483647, 32'h80000000, 32'h55555555, 32'haaaaaaaa, 7, -2000000000};
		n = 0;
		foreach (directed[i]) begin
			send_value(directed[i], draw_gap(n));
			n++;
		end
		repeat (RANDOM_ITEMS) begin
			send_value(random_value(), draw_gap(n));
			n++;
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.check_drained();

		$display("Converted %0d integers (%0d negative, %0d zero) into %0d characters, longest %0d.",
			sb.n_values, sb.n_negative, sb.n_zero, sb.n_chars, sb.longest);
		$display("Output side held off once for %0d cycles; %0d mismatches in %0d cycles.",
			held_cycles, sb.mismatches, cycle_count);
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
